// File: sv/rgbb_pkg.sv
package rgbb_pkg;

   localparam int unsigned GROUP_COUNT = 3;
   localparam int unsigned PHASE_W = 4;
   localparam int unsigned TIMEOUT_W = 6;
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_MAX = 6'd63;

   // active-low pin patterns, bit2 red bit1 green bit0 blue
   localparam logic [2:0] PINS_DARK = 3'b111;
   localparam logic [2:0] PINS_RED = 3'b011;
   localparam logic [2:0] PINS_GREEN = 3'b101;
   localparam logic [2:0] PINS_BLUE = 3'b110;
   localparam logic [2:0] PINS_WHITE = 3'b000;

   localparam logic [1:0] GROUP_LEFT = 2'd0;
   localparam logic [1:0] GROUP_RIGHT = 2'd1;
   localparam logic [1:0] GROUP_BASE = 2'd2;

   typedef enum logic [1:0] {
      OP_LED_CMD = 2'd0,
      OP_TICK = 2'd1,
      OP_TEST_START = 2'd2,
      OP_TEST_STOP = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      CLR_NONE = 3'd0,
      CLR_RED = 3'd1,
      CLR_GREEN = 3'd2,
      CLR_BLUE = 3'd3,
      CLR_WHITE = 3'd4
   } color_type;

   typedef enum logic [2:0] {
      CMD_ON = 3'd0,
      CMD_OFF = 3'd1,
      CMD_BLINK_OFF = 3'd2,
      CMD_SLOW = 3'd3,
      CMD_FAST = 3'd4,
      CMD_VERY_FAST = 3'd5
   } command_type;

   typedef enum logic [1:0] {
      MODE_STEADY = 2'd0,
      MODE_SLOW = 2'd1,
      MODE_FAST = 2'd2,
      MODE_VERY_FAST = 2'd3
   } mode_type;

   typedef struct packed {
      logic [1:0] operation;
      logic [1:0] body_part;
      logic [2:0] color;
      logic [2:0] command;
   } req_type;

   typedef struct packed {
      logic [2:0] left_pins;
      logic [2:0] right_pins;
      logic [2:0] base_pins;
      logic       self_test_running;
   } rsp_type;

   function automatic logic [2:0] color_pins(input logic [2:0] c);
      logic [2:0] pins;
      case (color_type'(c))
         CLR_RED: pins = PINS_RED;
         CLR_GREEN: pins = PINS_GREEN;
         CLR_BLUE: pins = PINS_BLUE;
         CLR_WHITE: pins = PINS_WHITE;
         default: pins = PINS_DARK;
      endcase
      return pins;
   endfunction

   function automatic logic [PHASE_W-1:0] period_of(input logic [1:0] m);
      logic [PHASE_W-1:0] p;
      case (mode_type'(m))
         MODE_SLOW: p = 4'd10;
         MODE_FAST: p = 4'd6;
         MODE_VERY_FAST: p = 4'd4;
         default: p = 4'd0;
      endcase
      return p;
   endfunction

   function automatic logic [PHASE_W-1:0] lit_of(input logic [1:0] m);
      logic [PHASE_W-1:0] p;
      case (mode_type'(m))
         MODE_SLOW: p = 4'd5;
         MODE_FAST: p = 4'd3;
         MODE_VERY_FAST: p = 4'd2;
         default: p = 4'd0;
      endcase
      return p;
   endfunction

endpackage

// File: sv/three_channel_rgb_blink_controller.sv
// a transaction passes from the input register to the result register
// throughput: one transaction per cycle, input register and result register each move
// whenever the result register is empty or being taken
// reset: synchronous active-high reset darkens all groups, clears blink patterns,
// the self-test timeout and both pipeline valid flags
module three_channel_rgb_blink_controller import rgbb_pkg::*; #(
   parameter int TICKS_PER_SECOND = 10
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   // self-test duration in ticks, saturated to the counter width
   localparam int LoadRaw = 5 * TICKS_PER_SECOND;
   localparam logic [TIMEOUT_W-1:0] TimeoutLoad =
      (LoadRaw > int'(TIMEOUT_MAX)) ? TIMEOUT_MAX : TIMEOUT_W'(LoadRaw);

   // input register stage
   logic    in_valid_ff;
   req_type in_ff;

   // result register stage
   logic    out_valid_ff;
   rsp_type out_ff;

   // per-group state
   logic [2:0]         color_ff [GROUP_COUNT];
   logic [1:0]         mode_ff  [GROUP_COUNT];
   logic [PHASE_W-1:0] phase_ff [GROUP_COUNT];
   logic [2:0]         pins_ff  [GROUP_COUNT];
   logic [TIMEOUT_W-1:0] timeout_ff;

   logic [2:0]         color_in [GROUP_COUNT];
   logic [1:0]         mode_in  [GROUP_COUNT];
   logic [PHASE_W-1:0] phase_in [GROUP_COUNT];
   logic [2:0]         pins_in  [GROUP_COUNT];
   logic [TIMEOUT_W-1:0] timeout_in;

   // pipeline moves when the result register is free or being drained
   logic advance;
   logic fire;

   assign advance = !out_valid_ff || !rsp_stall;
   assign fire = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;

   assign rsp_valid = out_valid_ff;
   assign rsp_data = out_ff;

   // next-state logic for the transaction held in the input register
   always_comb begin
      logic [PHASE_W:0] p_next;
      logic [1:0]       m;

      p_next = '0;
      m = '0;
      for (int g = 0; g < GROUP_COUNT; g++) begin
         color_in[g] = color_ff[g];
         mode_in[g] = mode_ff[g];
         phase_in[g] = phase_ff[g];
         pins_in[g] = pins_ff[g];
      end
      timeout_in = timeout_ff;

      case (op_type'(in_ff.operation))
         OP_LED_CMD: begin
            // unknown group or command codes leave everything alone
            for (int g = 0; g < GROUP_COUNT; g++) begin
               if (in_ff.body_part == 2'(g)) begin
                  case (command_type'(in_ff.command))
                     CMD_ON: begin
                        // blink pattern keeps running underneath
                        pins_in[g] = color_pins(in_ff.color);
                     end
                     CMD_OFF: begin
                        pins_in[g] = PINS_DARK;
                        color_in[g] = in_ff.color;
                        mode_in[g] = MODE_STEADY;
                        phase_in[g] = '0;
                     end
                     CMD_BLINK_OFF, CMD_SLOW, CMD_FAST, CMD_VERY_FAST: begin
                        // pins hold; a blinking mode updates them at the next tick
                        color_in[g] = in_ff.color;
                        mode_in[g] = 2'(in_ff.command - CMD_BLINK_OFF);
                        phase_in[g] = '0;
                     end
                     default: begin
                     end
                  endcase
               end
            end
         end
         OP_TICK: begin
            // blinking groups step first
            for (int g = 0; g < GROUP_COUNT; g++) begin
               m = mode_ff[g];
               if (mode_type'(m) != MODE_STEADY) begin
                  if (phase_ff[g] == '0) begin
                     pins_in[g] = color_pins(color_ff[g]);
                  end
                  if (phase_ff[g] == lit_of(m)) begin
                     pins_in[g] = PINS_DARK;
                  end
                  p_next = {1'b0, phase_ff[g]} + 1'b1;
                  if (p_next >= {1'b0, period_of(m)}) begin
                     phase_in[g] = '0;
                  end else begin
                     phase_in[g] = p_next[PHASE_W-1:0];
                  end
               end
            end
            // then the self-test timeout; expiry stops every group
            if (timeout_ff != '0) begin
               if (timeout_ff == TIMEOUT_W'(1)) begin
                  for (int g = 0; g < GROUP_COUNT; g++) begin
                     pins_in[g] = PINS_DARK;
                     color_in[g] = CLR_NONE;
                     mode_in[g] = MODE_STEADY;
                     phase_in[g] = '0;
                  end
               end
               timeout_in = timeout_ff - 1'b1;
            end
         end
         OP_TEST_START: begin
            timeout_in = TimeoutLoad;
            color_in[GROUP_LEFT] = CLR_RED;
            mode_in[GROUP_LEFT] = MODE_SLOW;
            phase_in[GROUP_LEFT] = '0;
            color_in[GROUP_RIGHT] = CLR_GREEN;
            mode_in[GROUP_RIGHT] = MODE_FAST;
            phase_in[GROUP_RIGHT] = '0;
            color_in[GROUP_BASE] = CLR_WHITE;
            mode_in[GROUP_BASE] = MODE_VERY_FAST;
            phase_in[GROUP_BASE] = '0;
         end
         OP_TEST_STOP: begin
            // timeout keeps counting
            for (int g = 0; g < GROUP_COUNT; g++) begin
               pins_in[g] = PINS_DARK;
               color_in[g] = CLR_NONE;
               mode_in[g] = MODE_STEADY;
               phase_in[g] = '0;
            end
         end
         default: begin
         end
      endcase
   end

   // input register: loads whenever it is empty or its transaction moves on
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
      if (!req_stall && req_valid) begin
         in_ff <= req_data;
      end
   end

   // group state commits as the transaction enters the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int g = 0; g < GROUP_COUNT; g++) begin
            color_ff[g] <= CLR_NONE;
            mode_ff[g] <= MODE_STEADY;
            phase_ff[g] <= '0;
            pins_ff[g] <= PINS_DARK;
         end
         timeout_ff <= '0;
      end else if (fire) begin
         for (int g = 0; g < GROUP_COUNT; g++) begin
            color_ff[g] <= color_in[g];
            mode_ff[g] <= mode_in[g];
            phase_ff[g] <= phase_in[g];
            pins_ff[g] <= pins_in[g];
         end
         timeout_ff <= timeout_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
      end
      if (fire) begin
         out_ff.left_pins <= pins_in[GROUP_LEFT];
         out_ff.right_pins <= pins_in[GROUP_RIGHT];
         out_ff.base_pins <= pins_in[GROUP_BASE];
         out_ff.self_test_running <= (timeout_in != '0);
      end
   end

endmodule
